>>> sv/abpt_pkg.sv
// ----------------------------------------------------------------------------
// abpt_pkg
// Shared widths, register indexes, op codes and reset values of the
// playback tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package abpt_pkg;

  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int RATE_W     = 17;
  localparam int CHAN_W     = 8;
  localparam int SBITS_W    = 6;
  localparam int BLK_W      = 16;
  localparam int BPS_W      = SBITS_W - 3;
  localparam int FRAME_W    = BPS_W + CHAN_W;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // op codes
  localparam logic [OP_W-1:0] OP_PLAY   = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
  localparam logic [OP_W-1:0] OP_STATUS = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
  localparam logic [OP_W-1:0] OP_SETPOS = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_ADPCM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BYTES   = 3'd5;

  // register reset values
  localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE = 17'd48000;
  localparam logic [CHAN_W-1:0]  RST_CHANNELS    = 8'd1;
  localparam logic [SBITS_W-1:0] RST_SAMPLE_BITS = 6'd16;
  localparam logic [BLK_W-1:0]   RST_BLOCK_BYTES = 16'd2;

  localparam logic [BLK_W-1:0]   ADPCM_DEFAULT_BLOCK = 16'd36;
  localparam logic [SBITS_W-1:0] PCM_DEFAULT_BITS    = 6'd16;
  localparam int                 ADPCM_SAMPLES_PER_BLOCK = 64;
  localparam int                 MS_PER_SECOND           = 1000;

  // sample count times ms per second, folded into one multiplier operand
  localparam logic [DATA_W-1:0] MS_SCALE_PCM   = DATA_W'(MS_PER_SECOND);
  localparam logic [DATA_W-1:0] MS_SCALE_ADPCM =
    DATA_W'(ADPCM_SAMPLES_PER_BLOCK * MS_PER_SECOND);

  typedef struct packed {
    logic              is_playing;
    logic              is_looping;
    logic [DATA_W-1:0] play_offset;
  } abpt_out_t;

  typedef struct packed {
    logic start;
    logic half;   // 32-bit dividend, 32 iterations
  } abpt_div_ctl_t;

endpackage

`default_nettype wire

>>> sv/abpt_if.sv
// ----------------------------------------------------------------------------
// abpt_if
// Request and response channels of the playback tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface abpt_in_if
  import abpt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic              loop_flag;
  logic [DATA_W-1:0] new_position;
  logic [DATA_W-1:0] now_ms;

  modport source (output valid, op, loop_flag, new_position, now_ms, input ready);
  modport sink   (input valid, op, loop_flag, new_position, now_ms, output ready);
endinterface

interface abpt_out_if
  import abpt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              is_playing;
  logic              is_looping;
  logic [DATA_W-1:0] play_offset;

  modport source (output valid, is_playing, is_looping, play_offset, input ready);
  modport sink   (input valid, is_playing, is_looping, play_offset, output ready);
endinterface

`default_nettype wire

>>> sv/abpt_mul.sv
// ----------------------------------------------------------------------------
// abpt_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module abpt_mul
  import abpt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] a_i,
  input  wire logic [DATA_W-1:0] b_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      prod_o
);

  localparam int CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] mcand_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DATA_W:0]   sum;

  // upper half accumulates, lower half holds the remaining multiplier bits
  always_comb begin
    sum    = {1'b0, prod_q[PROD_W-1:DATA_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
    prod_d = {sum, prod_q[DATA_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_i;
      prod_q  <= {{DATA_W{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> sv/abpt_div.sv
// ----------------------------------------------------------------------------
// abpt_div
// Bit-serial restoring divider, one quotient bit per cycle, 64 or 32 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module abpt_div
  import abpt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire abpt_div_ctl_t     ctl_i,
  input  wire logic [PROD_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      quot_o,
  output logic [DATA_W-1:0]      rem_o
);

  localparam int CNT_W = $clog2(PROD_W);

  logic [DATA_W-1:0] dvs_q, rem_q, rem_d;
  logic [PROD_W-1:0] sh_q, sh_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DATA_W:0]   trial;
  logic [DATA_W+1:0] diff;
  logic              ge;

  // partial remainder stays below the divisor, so 33 bits cover the trial
  always_comb begin
    trial = {rem_q, sh_q[PROD_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs_q};
    ge    = !diff[DATA_W+1];
    rem_d = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    sh_d  = {sh_q[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctl_i.half ? CNT_W'(DATA_W - 1) : CNT_W'(PROD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      sh_q  <= ctl_i.half ? {dividend_i[DATA_W-1:0], {DATA_W{1'b0}}} : dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> sv/audio_buffer_playback_tracker_core.sv
// ----------------------------------------------------------------------------
// audio_buffer_playback_tracker_core
// Play/stop/status/position tracking of one sound buffer against a ms clock.
// ----------------------------------------------------------------------------
// Sequencing: play, stop, status and unused ops go through ST_FIN to the
// response register. A timed position query runs the bit-serial multiplier,
// then the divider; a looping query first takes a modulo on the divider.
// Position set, when data and duration are nonzero, runs the multiplier, then
// the divider. Every register write recomputes the duration (divide, multiply,
// divide) and requests are held off until it finishes. One shift-add
// multiplier and one restoring divider are shared by all of these. The response
// register lets a new request enter while a response waits.
`default_nettype none

module audio_buffer_playback_tracker_core
  import abpt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  abpt_in_if.sink                   req_i,
  abpt_out_if.source                rsp_o
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] ST_FIN     = 4'd1;
  localparam logic [ST_W-1:0] ST_DUR_GO  = 4'd2;
  localparam logic [ST_W-1:0] ST_DUR_Q   = 4'd3;
  localparam logic [ST_W-1:0] ST_DUR_M   = 4'd4;
  localparam logic [ST_W-1:0] ST_DUR_D   = 4'd5;
  localparam logic [ST_W-1:0] ST_QRY_MOD = 4'd6;
  localparam logic [ST_W-1:0] ST_QRY_MUL = 4'd7;
  localparam logic [ST_W-1:0] ST_QRY_DIV = 4'd8;
  localparam logic [ST_W-1:0] ST_SET_MUL = 4'd9;
  localparam logic [ST_W-1:0] ST_SET_DIV = 4'd10;

  logic [ST_W-1:0]    state_q, state_d;
  logic [RATE_W-1:0]  rate_q;
  logic               adpcm_q;
  logic [CHAN_W-1:0]  chan_q;
  logic [SBITS_W-1:0] sbits_q;
  logic [BLK_W-1:0]   blk_q;
  logic [DATA_W-1:0]  data_q;

  logic               playing_q, playing_d;
  logic               looping_q, looping_d;
  logic [DATA_W-1:0]  start_q, start_d;
  logic [DATA_W-1:0]  stored_q, stored_d;
  logic [DATA_W-1:0]  dur_q, dur_d;
  logic [DATA_W-1:0]  now_q, now_d;
  abpt_out_t          res_q, res_d;
  abpt_out_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               cfg_hit;
  logic               req_fire;
  logic [DATA_W-1:0]  elapsed;
  logic               live, expired;
  logic [BPS_W-1:0]   bps;
  logic [CHAN_W-1:0]  chan_eff;
  logic [FRAME_W-1:0] frame;
  logic [BLK_W-1:0]   blk_eff;
  logic [SBITS_W-1:0] sbits_eff;

  logic               mul_start, mul_done;
  logic [DATA_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  mul_prod;
  abpt_div_ctl_t      div_ctl;
  logic               div_done;
  logic [PROD_W-1:0]  div_dvd, div_quot;
  logic [DATA_W-1:0]  div_dvs, div_rem;

  abpt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  abpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= REG_DATA_BYTES);

  assign req_i.ready = (state_q == ST_IDLE) && !cfg_we_i;
  assign req_fire    = req_i.valid && req_i.ready;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.is_playing  = out_q.is_playing;
  assign rsp_o.is_looping  = out_q.is_looping;
  assign rsp_o.play_offset = out_q.play_offset;

  // PCM frame size and ADPCM block size with their zero defaults
  assign sbits_eff = (sbits_q != '0) ? sbits_q : PCM_DEFAULT_BITS;
  assign bps       = sbits_eff[SBITS_W-1:3];
  assign chan_eff  = (chan_q != '0) ? chan_q : CHAN_W'(1);
  assign frame     = FRAME_W'(bps) * FRAME_W'(chan_eff);
  assign blk_eff   = (blk_q != '0) ? blk_q : ADPCM_DEFAULT_BLOCK;

  assign elapsed = req_i.now_ms - start_q;
  assign live    = playing_q && (looping_q || dur_q == '0 || elapsed < dur_q);
  assign expired = playing_q && !live;

  always_comb begin
    state_d     = state_q;
    playing_d   = playing_q;
    looping_d   = looping_q;
    start_d     = start_q;
    stored_d    = stored_q;
    dur_d       = dur_q;
    now_d       = now_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_start   = 1'b0;
    mul_a       = elapsed;
    mul_b       = data_q;
    div_ctl     = '0;
    div_dvd     = {{DATA_W{1'b0}}, elapsed};
    div_dvs     = dur_q;

    if (out_valid_q && rsp_o.ready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          res_d   = '0;
          now_d   = req_i.now_ms;
          state_d = ST_FIN;
          case (req_i.op)
            OP_PLAY: begin
              playing_d = 1'b1;
              looping_d = req_i.loop_flag;
              start_d   = req_i.now_ms;
            end
            OP_STOP: begin
              playing_d = 1'b0;
              stored_d  = '0;
            end
            OP_STATUS: begin
              if (expired) playing_d = 1'b0;
              res_d.is_playing = live;
              res_d.is_looping = live && looping_q;
            end
            OP_QUERY: begin
              res_d.play_offset = stored_q;
              if (data_q != '0) begin
                if (expired) playing_d = 1'b0;
                if (live && dur_q != '0) begin
                  if (looping_q) begin
                    div_ctl.start = 1'b1;
                    div_ctl.half  = 1'b1;
                    state_d       = ST_QRY_MOD;
                  end else begin
                    mul_start = 1'b1;
                    state_d   = ST_QRY_MUL;
                  end
                end
              end
            end
            OP_SETPOS: begin
              stored_d = req_i.new_position;
              if (data_q != '0 && dur_q != '0) begin
                mul_start = 1'b1;
                mul_a     = req_i.new_position;
                mul_b     = dur_q;
                state_d   = ST_SET_MUL;
              end
            end
            default: ;
          endcase
        end
      end

      ST_DUR_GO: begin
        if (rate_q == '0 || data_q == '0 || (!adpcm_q && frame == '0)) begin
          dur_d   = '0;
          state_d = ST_IDLE;
        end else begin
          div_ctl.start = 1'b1;
          div_ctl.half  = 1'b1;
          div_dvd       = {{DATA_W{1'b0}}, data_q};
          div_dvs       = adpcm_q ? DATA_W'(blk_eff) : DATA_W'(frame);
          state_d       = ST_DUR_Q;
        end
      end

      ST_DUR_Q: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = div_quot[DATA_W-1:0];
          mul_b     = adpcm_q ? MS_SCALE_ADPCM : MS_SCALE_PCM;
          state_d   = ST_DUR_M;
        end
      end

      ST_DUR_M: begin
        if (mul_done) begin
          div_ctl.start = 1'b1;
          div_dvd       = mul_prod;
          div_dvs       = DATA_W'(rate_q);
          state_d       = ST_DUR_D;
        end
      end

      ST_DUR_D: begin
        if (div_done) begin
          // saturate durations beyond 32 bits
          dur_d   = (|div_quot[PROD_W-1:DATA_W]) ? '1 : div_quot[DATA_W-1:0];
          state_d = ST_IDLE;
        end
      end

      ST_QRY_MOD: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = div_rem;
          state_d   = ST_QRY_MUL;
        end
      end

      ST_QRY_MUL: begin
        if (mul_done) begin
          div_ctl.start = 1'b1;
          div_dvd       = mul_prod;
          state_d       = ST_QRY_DIV;
        end
      end

      ST_QRY_DIV: begin
        if (div_done) begin
          if ((|div_quot[PROD_W-1:DATA_W]) || div_quot[DATA_W-1:0] > data_q)
            res_d.play_offset = data_q;
          else
            res_d.play_offset = div_quot[DATA_W-1:0];
          state_d = ST_FIN;
        end
      end

      ST_SET_MUL: begin
        if (mul_done) begin
          div_ctl.start = 1'b1;
          div_dvd       = mul_prod;
          div_dvs       = data_q;
          state_d       = ST_SET_DIV;
        end
      end

      ST_SET_DIV: begin
        if (div_done) begin
          start_d = now_q - div_quot[DATA_W-1:0];
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // any register write restarts the duration calculation
    if (cfg_hit) state_d = ST_DUR_GO;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= RST_SAMPLE_RATE;
      adpcm_q     <= 1'b0;
      chan_q      <= RST_CHANNELS;
      sbits_q     <= RST_SAMPLE_BITS;
      blk_q       <= RST_BLOCK_BYTES;
      data_q      <= '0;
      playing_q   <= 1'b0;
      looping_q   <= 1'b0;
      start_q     <= '0;
      stored_q    <= '0;
      dur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      playing_q   <= playing_d;
      looping_q   <= looping_d;
      start_q     <= start_d;
      stored_q    <= stored_d;
      dur_q       <= dur_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SAMPLE_RATE:  rate_q  <= cfg_wdata_i[RATE_W-1:0];
          REG_FORMAT_ADPCM: adpcm_q <= cfg_wdata_i[0];
          REG_CHANNELS:     chan_q  <= cfg_wdata_i[CHAN_W-1:0];
          REG_SAMPLE_BITS:  sbits_q <= cfg_wdata_i[SBITS_W-1:0];
          REG_BLOCK_BYTES:  blk_q   <= cfg_wdata_i[BLK_W-1:0];
          REG_DATA_BYTES:   data_q  <= cfg_wdata_i[DATA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_audio_buffer_playback_tracker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_audio_buffer_playback_tracker_core
// Self-checking testbench of the playback tracker. A behavioral model of the
// buffer (duration from format, liveness, position scaling) predicts every
// response. Directed checks cover reset defaults, one-shot expiry, looping,
// wrap of the ms clock, format corners and one long response stall. Random
// phases then reprogram all registers and run play/query sequences, with
// random idles on both channels in most phases.
// ----------------------------------------------------------------------------

module tb_audio_buffer_playback_tracker_core;
  import abpt_pkg::*;

  localparam int unsigned MAX_GAP         = 17;
  localparam int unsigned CFG_SETTLE      = 200;
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned RANDOM_PHASES   = 24;
  localparam int unsigned ITEMS_PER_PHASE = 26;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  abpt_in_if  req_if ();
  abpt_out_if rsp_if ();

  audio_buffer_playback_tracker_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the registers and the playback state
  logic [RATE_W-1:0]  mdl_rate    = RST_SAMPLE_RATE;
  logic               mdl_adpcm   = 1'b0;
  logic [CHAN_W-1:0]  mdl_chan    = RST_CHANNELS;
  logic [SBITS_W-1:0] mdl_sbits   = RST_SAMPLE_BITS;
  logic [BLK_W-1:0]   mdl_blk     = RST_BLOCK_BYTES;
  logic [DATA_W-1:0]  mdl_data    = '0;
  logic               mdl_playing = 1'b0;
  logic               mdl_looping = 1'b0;
  logic [DATA_W-1:0]  mdl_start   = '0;
  logic [DATA_W-1:0]  mdl_offset  = '0;
  logic [DATA_W-1:0]  mdl_dur     = '0;

  abpt_out_t   expected_rsp_q[$];
  int unsigned req_count    = 0;
  int unsigned rsp_count    = 0;
  int unsigned cfg_count    = 0;
  int unsigned err_count    = 0;
  int unsigned stall_cycles = 0;
  bit          idle_on      = 1'b1;
  bit          hold_rsp     = 1'b0;
  logic [DATA_W-1:0] clock_ms = '0;

  function automatic logic [DATA_W-1:0] buffer_duration_ms();
    logic [PROD_W-1:0] samples;
    logic [PROD_W-1:0] ms;
    logic [DATA_W-1:0] blk;
    logic [DATA_W-1:0] bps;
    logic [DATA_W-1:0] frame;
    if (mdl_rate == '0 || mdl_data == '0) return '0;
    if (mdl_adpcm) begin
      blk = (mdl_blk != '0) ? DATA_W'(mdl_blk) : DATA_W'(ADPCM_DEFAULT_BLOCK);
      samples = PROD_W'(mdl_data / blk) * PROD_W'(ADPCM_SAMPLES_PER_BLOCK);
    end else begin
      bps = DATA_W'((mdl_sbits != '0) ? mdl_sbits : PCM_DEFAULT_BITS) >> 3;
      frame = bps * ((mdl_chan != '0) ? DATA_W'(mdl_chan) : DATA_W'(1));
      samples = (frame != '0) ? PROD_W'(mdl_data / frame) : '0;
    end
    ms = samples * PROD_W'(MS_PER_SECOND) / PROD_W'(mdl_rate);
    return (ms > PROD_W'(32'hFFFF_FFFF)) ? '1 : ms[DATA_W-1:0];
  endfunction

  // a one-shot buffer drops its playing flag once it is seen expired
  function automatic bit buffer_live(logic [DATA_W-1:0] now);
    logic [DATA_W-1:0] elapsed;
    elapsed = now - mdl_start;
    if (!mdl_playing) return 1'b0;
    if (mdl_looping || mdl_dur == '0) return 1'b1;
    if (elapsed < mdl_dur) return 1'b1;
    mdl_playing = 1'b0;
    return 1'b0;
  endfunction

  function automatic abpt_out_t predict_event(logic [OP_W-1:0] op, logic loop,
                                              logic [DATA_W-1:0] pos,
                                              logic [DATA_W-1:0] now);
    abpt_out_t         res;
    logic [DATA_W-1:0] elapsed;
    logic [PROD_W-1:0] scaled;
    bit                timed;
    res = '0;
    timed = 1'b0;
    case (op)
      OP_PLAY: begin
        mdl_playing = 1'b1;
        mdl_looping = loop;
        mdl_start = now;
      end
      OP_STOP: begin
        mdl_playing = 1'b0;
        mdl_offset = '0;
      end
      OP_STATUS: begin
        if (buffer_live(now)) begin
          res.is_playing = 1'b1;
          res.is_looping = mdl_looping;
        end
      end
      OP_QUERY: begin
        // liveness is only evaluated when there is data
        if (mdl_data != '0) timed = buffer_live(now) && (mdl_dur != '0);
        if (timed) begin
          elapsed = now - mdl_start;
          if (mdl_looping) elapsed = elapsed % mdl_dur;
          scaled = PROD_W'(elapsed) * PROD_W'(mdl_data) / PROD_W'(mdl_dur);
          res.play_offset = (scaled > PROD_W'(mdl_data)) ? mdl_data : scaled[DATA_W-1:0];
        end else begin
          res.play_offset = mdl_offset;
        end
      end
      OP_SETPOS: begin
        mdl_offset = pos;
        if (mdl_data != '0 && mdl_dur != '0) begin
          scaled = PROD_W'(pos) * PROD_W'(mdl_dur) / PROD_W'(mdl_data);
          mdl_start = now - scaled[DATA_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_req(logic [OP_W-1:0] op, logic loop, logic [DATA_W-1:0] pos,
                          logic [DATA_W-1:0] now);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.loop_flag    <= loop;
    req_if.new_position <= pos;
    req_if.now_ms       <= now;
    do @(posedge clk); while (!req_if.ready);
    expected_rsp_q.push_back(predict_event(op, loop, pos, now));
    req_count++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // only while idle; the block recomputes the duration after every write to a mapped register
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_count++;
    case (idx)
      REG_SAMPLE_RATE:  mdl_rate  = value[RATE_W-1:0];
      REG_FORMAT_ADPCM: mdl_adpcm = value[0];
      REG_CHANNELS:     mdl_chan  = value[CHAN_W-1:0];
      REG_SAMPLE_BITS:  mdl_sbits = value[SBITS_W-1:0];
      REG_BLOCK_BYTES:  mdl_blk   = value[BLK_W-1:0];
      REG_DATA_BYTES:   mdl_data  = value;
      default: ;
    endcase
    if (idx <= REG_DATA_BYTES) mdl_dur = buffer_duration_ms();
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  // unused upper bits of the write data must not matter
  function automatic logic [CFG_DATA_W-1:0] add_noise(logic [CFG_DATA_W-1:0] v,
                                                      int unsigned width);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    if (width >= CFG_DATA_W || $urandom_range(0, 3) != 0) return v;
    return v | (noise << width);
  endfunction

  task automatic test_reset_defaults();
    send_req(OP_STATUS, 1'b0, '0, '0);
    send_req(OP_QUERY, 1'b1, '1, '1);
    send_req(OP_PLAY, 1'b1, '0, '1);
    send_req(OP_STATUS, 1'b0, '0, 32'd3);
    send_req(OP_SETPOS, 1'b0, '1, 32'd4);
    send_req(OP_QUERY, 1'b0, '0, 32'd5);
    send_req(OP_STOP, 1'b1, '1, '1);
    send_req(OP_QUERY, 1'b0, '0, 32'd6);
    for (int k = 1; k <= 3; k++) send_req(OP_SETPOS + OP_W'(k), 1'b1, '1, '1);
    wait_idle();
  endtask

  // 16-bit mono at 48 kHz, 96000 bytes: 1000 ms, started just before the wrap
  task automatic test_one_shot_timing();
    logic [DATA_W-1:0] t0;
    t0 = 32'hFFFF_FE00;
    write_cfg(REG_DATA_BYTES, 32'd96000);
    send_req(OP_PLAY, 1'b0, '0, t0);
    send_req(OP_QUERY, 1'b0, '0, t0 + 32'd500);
    send_req(OP_STATUS, 1'b0, '0, t0 + 32'd999);
    send_req(OP_STATUS, 1'b0, '0, t0 + 32'd1000);
    send_req(OP_QUERY, 1'b0, '0, t0 + 32'd1001);
    send_req(OP_PLAY, 1'b1, '0, t0 + 32'd2000);
    send_req(OP_QUERY, 1'b0, '0, t0 + 32'd4500);
    send_req(OP_SETPOS, 1'b0, '1, t0 + 32'd5000);
    send_req(OP_QUERY, 1'b0, '0, t0 + 32'd5000);
    send_req(OP_STATUS, 1'b0, '0, t0 + 32'd9000);
    wait_idle();
  endtask

  task automatic test_format_corners();
    // no sample rate: zero duration
    write_cfg(REG_SAMPLE_RATE, '0);
    send_req(OP_PLAY, 1'b0, '0, 32'd100);
    send_req(OP_QUERY, 1'b0, '0, 32'd100000);
    wait_idle();
    // 4-bit samples give an empty frame
    write_cfg(REG_SAMPLE_RATE, CFG_DATA_W'(RST_SAMPLE_RATE));
    write_cfg(REG_SAMPLE_BITS, 32'd4);
    send_req(OP_STATUS, 1'b0, '0, 32'h8000_0000);
    wait_idle();
    // saturated duration: 1-byte ADPCM blocks of a full-size buffer at 4 kHz
    write_cfg(REG_FORMAT_ADPCM, 32'd1);
    write_cfg(REG_BLOCK_BYTES, 32'd1);
    write_cfg(REG_DATA_BYTES, '1);
    write_cfg(REG_SAMPLE_RATE, 32'd4000);
    send_req(OP_QUERY, 1'b0, '0, 32'h7FFF_FFFF);
    send_req(OP_SETPOS, 1'b1, 32'h8000_0000, 32'h0000_0010);
    send_req(OP_QUERY, 1'b0, '0, 32'h0000_1000);
    wait_idle();
    // writes to unmapped indexes are dropped
    for (int k = 1; k <= 2; k++) write_cfg(REG_DATA_BYTES + CFG_IDX_W'(k), '1);
    send_req(OP_STATUS, 1'b0, '0, 32'h0000_2000);
    wait_idle();
  endtask

  task automatic test_output_stall();
    idle_on = 1'b0;
    hold_rsp = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_req(OP_STATUS + OP_W'(i % 3), 1'($urandom), $urandom, clock_ms);
      clock_ms = clock_ms + $urandom_range(0, 5000);
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic pick_config();
    int unsigned           sel;
    logic [CFG_DATA_W-1:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 8) v = '0;
    else if (sel < 13) v = 32'd1;
    else if (sel < 23) v = 32'd4000;
    else if (sel < 33) v = 32'd96000;
    else if (sel < 38) v = 32'h1FFFF;
    else v = $urandom_range(4000, 96000);
    write_cfg(REG_SAMPLE_RATE, add_noise(v, RATE_W));
    write_cfg(REG_FORMAT_ADPCM, add_noise(CFG_DATA_W'($urandom_range(0, 1)), 1));
    sel = $urandom_range(0, 99);
    if (sel < 10) v = '0;
    else if (sel < 30) v = 32'd1;
    else if (sel < 40) v = 32'd2;
    else if (sel < 50) v = 32'd255;
    else v = $urandom_range(0, 255);
    write_cfg(REG_CHANNELS, add_noise(v, CHAN_W));
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = '0;
      1: v = 32'd4;
      2: v = 32'd8;
      3: v = 32'd16;
      4: v = 32'd24;
      5: v = 32'd32;
      6: v = 32'd63;
      default: v = $urandom_range(0, 63);
    endcase
    write_cfg(REG_SAMPLE_BITS, add_noise(v, SBITS_W));
    sel = $urandom_range(0, 99);
    if (sel < 10) v = '0;
    else if (sel < 20) v = 32'd1;
    else if (sel < 30) v = 32'd36;
    else if (sel < 40) v = 32'hFFFF;
    else v = $urandom_range(1, 4096);
    write_cfg(REG_BLOCK_BYTES, add_noise(v, BLK_W));
    sel = $urandom_range(0, 99);
    if (sel < 8) v = '0;
    else if (sel < 16) v = '1;
    else if (sel < 30) v = $urandom;
    else v = $urandom_range(1, 4_000_000);
    write_cfg(REG_DATA_BYTES, v);
    if ($urandom_range(0, 4) == 0)
      write_cfg(REG_DATA_BYTES + CFG_IDX_W'($urandom_range(1, 2)), $urandom);
  endtask

  // plays followed by runs of queries with the clock creeping toward expiry
  task automatic run_traffic(int unsigned n_items);
    int unsigned       sel;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] pos;
    logic [DATA_W-1:0] span;
    clock_ms = $urandom;
    send_req(OP_PLAY, 1'($urandom), $urandom, clock_ms);
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) op = OP_PLAY;
      else if (sel < 23) op = OP_STOP;
      else if (sel < 48) op = OP_STATUS;
      else if (sel < 83) op = OP_QUERY;
      else if (sel < 95) op = OP_SETPOS;
      else op = OP_SETPOS + OP_W'($urandom_range(1, 3));
      if (mdl_dur == '0) span = 32'd2000;
      else if (mdl_dur > 32'd3_000_000) span = 32'd1_000_000;
      else span = mdl_dur / 3 + 1;
      sel = $urandom_range(0, 99);
      if (sel < 10) ;
      else if (sel < 20) clock_ms = $urandom;
      else if (sel < 28) clock_ms = mdl_start + mdl_dur - 1 + $urandom_range(0, 2);
      else clock_ms = clock_ms + $urandom_range(0, span);
      sel = $urandom_range(0, 99);
      if (op != OP_SETPOS || sel < 25) pos = $urandom;
      else if (sel < 40) pos = mdl_data;
      else pos = $urandom_range(0, mdl_data);
      send_req(op, 1'($urandom), pos, clock_ms);
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      pick_config();
      idle_on = ($urandom_range(0, 3) != 0);
      run_traffic(ITEMS_PER_PHASE);
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  // response sink with random ready gaps and an optional long hold
  initial begin : rsp_sink
    int unsigned gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid && !hold_rsp);
    end
  end

  always @(posedge clk) begin : rsp_check
    abpt_out_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      rsp_count++;
      if (expected_rsp_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected response, expected none, actual %0b/%0b/%0h", $time,
                 rsp_if.is_playing, rsp_if.is_looping, rsp_if.play_offset);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_if.is_playing !== want.is_playing) begin
          err_count++;
          $display("%0t: is_playing mismatch, expected %0b actual %0b", $time,
                   want.is_playing, rsp_if.is_playing);
        end
        if (rsp_if.is_looping !== want.is_looping) begin
          err_count++;
          $display("%0t: is_looping mismatch, expected %0b actual %0b", $time,
                   want.is_looping, rsp_if.is_looping);
        end
        if (rsp_if.play_offset !== want.play_offset) begin
          err_count++;
          $display("%0t: play_offset mismatch, expected %0h actual %0h", $time,
                   want.play_offset, rsp_if.play_offset);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d responses outstanding", $time,
               STALL_LIMIT, expected_rsp_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    req_if.valid        = 1'b0;
    req_if.op           = '0;
    req_if.loop_flag    = 1'b0;
    req_if.new_position = '0;
    req_if.now_ms       = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_one_shot_timing();
    test_format_corners();
    test_output_stall();
    test_random_traffic();

    wait_idle();
    repeat (CFG_SETTLE) @(posedge clk);
    $display("Ran %0d requests, %0d responses, %0d register writes, %0d mismatches",
             req_count, rsp_count, cfg_count, err_count);
    $display("Directed corners, %0d random register settings and one long output stall",
             RANDOM_PHASES);
    if (err_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
